// File: rtl/ffd_pkg.sv
// fractional feedback delay: shared types, register indexes and default sizes
// used by every module of the block but the store; no dependencies

package ffd_pkg;

  // default sizes, handed to the top level parameters
  localparam int DEPTH_DEFAULT         = 4096;
  localparam int SAMPLE_BITS_DEFAULT   = 16;
  localparam int FRACTION_BITS_DEFAULT = 8;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 21;
  localparam int DELAY_BITS     = 21;
  localparam int GAIN_BITS      = 17;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN = 2'd1;

  // register reset values and limits
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 21'd256;
  localparam logic [DELAY_BITS-1:0] DELAY_MIN   = 21'd1;
  localparam logic [GAIN_BITS-1:0]  GAIN_ONE    = 17'h10000;
  localparam int                    GAIN_SHIFT  = 16;

  // operand select of the shared multiplier
  typedef enum logic [1:0] {
    MUL_NEAR,
    MUL_FAR,
    MUL_GAIN
  } mul_src_t;

  // per-step datapath controls issued by the sequencer
  typedef struct packed {
    logic     take;       // input word accepted this cycle
    logic     mem_rd;     // read the delay store
    logic     rd_far;     // read the far neighbour instead of the near one
    mul_src_t mul_src;
    logic     prod_load;  // register the multiplier result
    logic     acc_load;   // product register plus multiplier into accumulator
    logic     commit;     // write back, advance write position, present output
  } ffd_ctrl_t;

endpackage

// File: rtl/ffd_store.sv
// fractional feedback delay: circular sample store, one write and one read port
// read data registered; depends on nothing but its parameters

module ffd_store #(
  parameter int DEPTH       = 4096,
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 12
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [SAMPLE_BITS-1:0] rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_data
);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ffd_sequencer.sv
// fractional feedback delay: microcode sequencer, step counter and control rom
// depends on ffd_pkg for the control word handed to the datapath

module ffd_sequencer import ffd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      out_busy,
  output ffd_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_NEAR,
    ST_RD_FAR,
    ST_BLEND,
    ST_FEEDBACK,
    ST_COMMIT
  } step_t;

  // condition under which a step moves on
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_INPUT,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    cond_t    cond;
    step_t    next;
    logic     mem_rd;
    logic     rd_far;
    mul_src_t mul_src;
    logic     prod_load;
    logic     acc_load;
    logic     commit;
  } uword_t;

  // control program
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{cond: COND_ALWAYS, next: ST_IDLE, mem_rd: 1'b0, rd_far: 1'b0,
          mul_src: MUL_NEAR, prod_load: 1'b0, acc_load: 1'b0, commit: 1'b0};
    unique case (s)
      ST_IDLE: begin
        w.cond = COND_INPUT;
        w.next = ST_RD_NEAR;
      end
      ST_RD_NEAR: begin
        w.mem_rd = 1'b1;
        w.next   = ST_RD_FAR;
      end
      ST_RD_FAR: begin
        w.mem_rd    = 1'b1;
        w.rd_far    = 1'b1;
        w.mul_src   = MUL_NEAR;
        w.prod_load = 1'b1;
        w.next      = ST_BLEND;
      end
      ST_BLEND: begin
        w.mul_src  = MUL_FAR;
        w.acc_load = 1'b1;
        w.next     = ST_FEEDBACK;
      end
      ST_FEEDBACK: begin
        w.mul_src   = MUL_GAIN;
        w.prod_load = 1'b1;
        w.next      = ST_COMMIT;
      end
      ST_COMMIT: begin
        w.cond   = COND_OUT_FREE;
        w.commit = 1'b1;
        w.next   = ST_IDLE;
      end
      default: begin
        w.next = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  step_t  step;
  step_t  step_next;
  uword_t word;
  logic   cond_ok;

  // decode current step and its jump condition
  always_comb begin
    word = ucode(step);
    unique case (word.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_INPUT:    cond_ok = in_valid;
      COND_OUT_FREE: cond_ok = !out_busy;
      default:       cond_ok = 1'b1;
    endcase
    step_next = cond_ok ? word.next : step;
  end

  assign in_stall = (word.cond != COND_INPUT);

  assign ctrl = '{take:      (word.cond == COND_INPUT) && in_valid,
                  mem_rd:    word.mem_rd,
                  rd_far:    word.rd_far,
                  mul_src:   word.mul_src,
                  prod_load: word.prod_load,
                  acc_load:  word.acc_load,
                  commit:    word.commit && cond_ok};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: rtl/ffd_datapath.sv
// fractional feedback delay: address generation, shared multiplier, blend,
// feedback write-back, configuration registers and output register
// depends on ffd_pkg and ffd_store

module ffd_datapath import ffd_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEFAULT,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ffd_ctrl_t                        ctrl,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in,
  input  logic                             cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic signed [SAMPLE_BITS-1:0]    sample_out
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SB   = SAMPLE_BITS;
  localparam int F    = FRACTION_BITS;
  localparam int PW   = (AW + F + 2 > DELAY_BITS + 2) ? AW + F + 2 : DELAY_BITS + 2;
  localparam int WB   = F + 1;
  localparam int MBW  = ((WB > GAIN_BITS) ? WB : GAIN_BITS) + 1;
  localparam int PRW  = SB + MBW;
  localparam int ACW  = SB + F + 2;
  localparam int SUMW = SB + 2;

  localparam logic [PW-1:0] MAX_POS   = PW'(DEPTH) << F;
  localparam logic [DELAY_BITS-1:0] DELAY_INIT =
    (MAX_POS < PW'(DELAY_RESET)) ? MAX_POS[DELAY_BITS-1:0] : DELAY_RESET;
  localparam logic [WB-1:0] SCALE     = WB'(1) << F;
  localparam logic [WB-1:0] FRAC_MASK = SCALE - WB'(1);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic signed [SUMW-1:0] SAT_HI = (SUMW'(1) << (SB - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

  // configuration and position state
  logic [DELAY_BITS-1:0] delay_length;
  logic [GAIN_BITS-1:0]  feedback_gain;
  logic [AW-1:0]         write_pos;
  logic                  wrapped;

  // per-word registers
  logic signed [SB-1:0]  x_q;
  logic [AW-1:0]         near_q;
  logic [AW-1:0]         far_q;
  logic [WB-1:0]         frac_q;
  logic                  near_ok;
  logic                  far_ok;
  logic signed [PRW-1:0] prod_q;
  logic signed [ACW-1:0] acc_q;

  logic [SB-1:0]         rd_data;
  logic [PW-1:0]         pos;
  logic [AW:0]           whole;
  logic [AW:0]           near_wide;
  logic [AW-1:0]         near_c;
  logic [AW-1:0]         far_c;
  logic signed [SB-1:0]  mul_a;
  logic [MBW-2:0]        mul_b;
  logic signed [PRW-1:0] mul_res;
  logic signed [SB-1:0]  y;
  logic signed [SB:0]    fb;
  logic signed [SUMW-1:0] sum;
  logic signed [SB-1:0]  wb_data;
  logic [DELAY_BITS-1:0] delay_wr;
  logic [GAIN_BITS-1:0]  gain_wr;

  // read position behind the write position, split into index and fraction
  always_comb begin
    pos       = (PW'(write_pos) << F) + MAX_POS - PW'(delay_length);
    whole     = pos[F +: AW + 1];
    near_wide = (whole >= DEPTH_W) ? whole - DEPTH_W : whole;
    near_c    = near_wide[AW-1:0];
    far_c     = (near_c == LAST_IDX) ? '0 : near_c + AW'(1);
  end

  // capture input word and addresses; entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      x_q     <= sample_in;
      near_q  <= near_c;
      far_q   <= far_c;
      frac_q  <= pos[F:0] & FRAC_MASK;
      near_ok <= wrapped || (near_c < write_pos);
      far_ok  <= wrapped || (far_c < write_pos);
    end
  end

  ffd_store #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SB),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (ctrl.mem_rd),
    .rd_addr (ctrl.rd_far ? far_q : near_q),
    .rd_data (rd_data),
    .wr_en   (ctrl.commit),
    .wr_addr (write_pos),
    .wr_data (wb_data)
  );

  assign y = acc_q[F +: SB];

  // shared multiplier operand select
  always_comb begin
    case (ctrl.mul_src)
      MUL_NEAR: begin
        mul_a = near_ok ? $signed(rd_data) : '0;
        mul_b = (MBW - 1)'(SCALE - frac_q);
      end
      MUL_FAR: begin
        mul_a = far_ok ? $signed(rd_data) : '0;
        mul_b = (MBW - 1)'(frac_q);
      end
      MUL_GAIN: begin
        mul_a = y;
        mul_b = (MBW - 1)'(feedback_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_res = PRW'(mul_a) * PRW'($signed({1'b0, mul_b}));
  end

  // product and blend accumulator
  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      prod_q <= mul_res;
    end
    if (ctrl.acc_load) begin
      acc_q <= ACW'(prod_q) + ACW'(mul_res);
    end
  end

  // feedback sum, saturated to the sample range
  always_comb begin
    fb  = prod_q[GAIN_SHIFT +: SB + 1];
    sum = SUMW'(x_q) + SUMW'(fb);
    if (sum > SAT_HI) begin
      wb_data = SAT_HI[SB-1:0];
    end else if (sum < SAT_LO) begin
      wb_data = SAT_LO[SB-1:0];
    end else begin
      wb_data = sum[SB-1:0];
    end
  end

  // clamped register write values
  always_comb begin
    delay_wr = cfg_data[DELAY_BITS-1:0];
    if (delay_wr < DELAY_MIN) begin
      delay_wr = DELAY_MIN;
    end else if (PW'(delay_wr) > MAX_POS) begin
      delay_wr = MAX_POS[DELAY_BITS-1:0];
    end
    gain_wr = cfg_data[GAIN_BITS-1:0];
    if (gain_wr > GAIN_ONE) begin
      gain_wr = GAIN_ONE;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= DELAY_INIT;
      feedback_gain <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DELAY_LENGTH:  delay_length  <= delay_wr;
        REG_FEEDBACK_GAIN: feedback_gain <= gain_wr;
        default: ;
      endcase
    end
  end

  // write position and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      wrapped   <= 1'b0;
    end else if (ctrl.commit) begin
      if (write_pos == LAST_IDX) begin
        write_pos <= '0;
        wrapped   <= 1'b1;
      end else begin
        write_pos <= write_pos + AW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      sample_out <= y;
    end
  end

endmodule

// File: rtl/fractional_feedback_delay.sv
// fractional feedback delay: top level joining sequencer and datapath
// depends on ffd_pkg, ffd_sequencer and ffd_datapath
//
// usage:
//   input channel in_valid/in_stall carries one signed sample_in per word;
//   output channel out_valid/out_stall returns one sample_out per input word,
//   the store read delay_length (8 fraction bits) behind the write position,
//   linearly interpolated; input plus scaled output is written back.
//   cfg_write with cfg_index/cfg_data sets delay_length (index 0) and
//   feedback_gain (index 1); write only while no word is in flight.
// timing:
//   from acceptance until sample_out is loaded into the output register,
//   the microcode program runs one step per cycle (the commit step waits
//   while the output register is busy), with two store reads on the single
//   read port and three passes through the shared multiplier. No new word
//   is taken before the last commits: in_stall is low only in the idle step.
// reset and stall:
//   rst clears the program counter, write position, output valid and
//   registers (delay 1.0 sample, gain 0); the store needs no clearing pass,
//   entries not yet written since reset read as zero.
//   while out_stall holds a result, the next word is still accepted and
//   computed; its write-back waits until the output register is free.

module fractional_feedback_delay import ffd_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEFAULT,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  ffd_ctrl_t ctrl;
  logic      out_busy;

  // output register still holds a word the receiver has not taken
  assign out_busy = out_valid && out_stall;

  ffd_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  ffd_datapath #(
    .DEPTH         (DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample_in  (sample_in),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .sample_out (sample_out)
  );

endmodule

// File: rtl/ffd_checker.sv
// fractional feedback delay: port-level checker and its bind to the top level
// depends on ffd_pkg and fractional_feedback_delay

module ffd_checker import ffd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_out
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("stalled output word changed or vanished");

  // the block is busy right after taking a word
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again in the cycle after a word");

  // a result needs several program steps after acceptance
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=>
      !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result appeared too early");

  // a new result only appears while a word is being worked on
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a word in flight");

  // reset empties the output register
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind fractional_feedback_delay ffd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ffd_checker (.*);
